>>> rtl/strt_pkg.sv
// ----------------------------------------------------------------------------
// strt_pkg
// Shared types and constants of the sequence/timestamp range tracker.
// ----------------------------------------------------------------------------
package strt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam logic [15:0] SEQ_HALF  = 16'h7FFF;
   localparam logic [15:0] EPOCH_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_CHECK = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_DUMP  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RES_COVER = 2'd0,
      RES_MISS  = 2'd1,
      RES_DUMP  = 2'd2
   } res_kind_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [31:0] start;
      logic [15:0] dur;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } tbl_wr_type;

   typedef struct packed {
      res_kind_type kind;
      logic [31:0]  seq;
      logic [31:0]  start;
      logic [15:0]  dur;
      logic [31:0]  miss;
      logic         last;
   } result_type;

endpackage

>>> rtl/strt_table.sv
// ----------------------------------------------------------------------------
// strt_table
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module strt_table (
   input  logic                            clock,
   input  strt_pkg::tbl_wr_type            wr,
   input  logic [strt_pkg::IDX_W-1:0]      rd_addr,
   output strt_pkg::entry_type             rd_data
);
   import strt_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/strt_epoch.sv
// ----------------------------------------------------------------------------
// strt_epoch
// Extend a 16-bit sequence number with the epoch of the highest number seen,
// adjusted by one when the number wraps.
module strt_epoch (
   input  logic [31:0] highest,
   input  logic [15:0] seq16,
   output logic [31:0] seq_ext,
   output logic [31:0] highest_next
);
   import strt_pkg::*;

   logic [15:0] old_lo;
   logic [15:0] epoch;

   always_comb begin
      old_lo = highest[15:0];
      epoch  = highest[31:16];
      if (old_lo > seq16 && (old_lo - seq16) > SEQ_HALF) begin
         epoch = (epoch == EPOCH_MAX) ? 16'd0 : epoch + 16'd1;
      end else if (seq16 > old_lo && (seq16 - old_lo) > SEQ_HALF) begin
         if (epoch != 16'd0) begin
            epoch = epoch - 16'd1;
         end
      end
      seq_ext      = {epoch, seq16};
      highest_next = (seq_ext > highest) ? seq_ext : highest;
   end

endmodule

>>> rtl/seq_timestamp_range_tracker_core.sv
// ----------------------------------------------------------------------------
// seq_timestamp_range_tracker_core
// Sorted packet table with add, range check, clear and dump transactions.
// ----------------------------------------------------------------------------
// The block takes one request transaction at a time and works on it alone.
// All entries live in one memory with a single read port and registered
// read data. Add, check and dump walk the sorted table through that port,
// one entry per cycle save for missing-run reports and back-pressure stalls.
// An add searches upward for its slot and replaces an equal entry in place,
// or shifts the entries above the slot up and writes the new one; when full,
// it shifts lower entries down over the lowest, or drops a new lowest packet.
// A check skips to the first overlap, then reports each covered entry and
// missing run; a dump reports every entry; a clear resets the count.
// Results pass through a holding and an output register, so back-pressure
// stalls the walk and the final flush. The table starts empty after reset
// with no clearing pass; clear keeps the highest sequence number seen.
// ----------------------------------------------------------------------------
module seq_timestamp_range_tracker_core (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [95:0]   req_tdata,   // seq_number[15:0], ts_begin[47:16],
                                      // ts_end[79:48], duration[95:80]
   input  logic [1:0]    req_tuser,   // kind[1:0]
   // result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,   // seq_out[31:0], ts_start_out[63:32],
                                      // dur_out[79:64], miss_count[111:80]
   output logic [1:0]    rsp_tuser,   // result_kind[1:0]
   output logic          rsp_tlast    // last
);
   import strt_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_ADD_SRCH = 9'b000000010,
      ST_SHIFT_UP = 9'b000000100,
      ST_SHIFT_DN = 9'b000001000,
      ST_WR_NEW   = 9'b000010000,
      ST_CHK_FIND = 9'b000100000,
      ST_CHK_WALK = 9'b001000000,
      ST_DUMP     = 9'b010000000,
      ST_FINISH   = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;     // search position / walk position
   logic [COUNT_W-1:0] k_ff, k_in;         // shift write position
   logic [IDX_W-1:0]   ins_ff, ins_in;     // slot for the new entry
   logic               grow_ff, grow_in;
   logic               gap_done_ff, gap_done_in;
   logic [31:0]        highest_ff, highest_in;
   logic [31:0]        prev_ff, prev_in;
   logic [31:0]        seq_ff, seq_in;
   logic [31:0]        b_ff, b_in;
   logic [31:0]        e_ff, e_in;
   logic [15:0]        dur_ff, dur_in;

   result_type         pend_ff;
   logic               pend_v_ff;
   result_type         out_ff;
   logic               out_v_ff;
   result_type         push_res;

   tbl_wr_type         wr;
   logic [IDX_W-1:0]   rd_addr;
   entry_type          rd;

   logic [31:0]        seq_ext;
   logic [31:0]        highest_next;

   logic               accept;
   logic               can_push;
   logic               emit_ok;
   logic               emit_req;
   logic               fin_req;
   result_type         emit_res;

   logic [31:0]        stop;
   logic               overlap;
   logic [31:0]        gap;
   logic               at_end;

   strt_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd)
   );

   strt_epoch u_epoch (
      .highest      (highest_ff),
      .seq16        (req_tdata[15:0]),
      .seq_ext      (seq_ext),
      .highest_next (highest_next)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign can_push   = !out_v_ff || rsp_tready;
   assign emit_ok    = !pend_v_ff || can_push;

   // entry that arrives from the read issued last cycle
   assign stop    = rd.start + {16'd0, rd.dur};
   assign overlap = (rd.start <= e_ff) && (b_ff <= stop);
   assign gap     = rd.seq - prev_ff;
   assign at_end  = (idx_ff == count_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      k_in        = k_ff;
      ins_in      = ins_ff;
      grow_in     = grow_ff;
      gap_done_in = gap_done_ff;
      highest_in  = highest_ff;
      prev_in     = prev_ff;
      seq_in      = seq_ff;
      b_in        = b_ff;
      e_in        = e_ff;
      dur_in      = dur_ff;
      wr          = '0;
      rd_addr     = idx_ff[IDX_W-1:0];
      emit_req    = 1'b0;
      fin_req     = 1'b0;
      emit_res    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (accept) begin
               idx_in = '0;
               b_in   = req_tdata[47:16];
               e_in   = req_tdata[79:48];
               dur_in = req_tdata[95:80];
               unique case (kind_type'(req_tuser))
                  KIND_ADD: begin
                     seq_in     = seq_ext;
                     highest_in = highest_next;
                     state_in   = ST_ADD_SRCH;
                  end
                  KIND_CHECK: state_in = ST_CHK_FIND;
                  KIND_CLEAR: count_in = '0;
                  KIND_DUMP:  state_in = ST_DUMP;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end

         ST_ADD_SRCH: begin
            if (at_end || rd.seq > seq_ff) begin
               if (count_ff == COUNT_W'(TABLE_DEPTH)) begin
                  grow_in = 1'b0;
                  if (idx_ff == '0) begin
                     state_in = ST_IDLE;          // new packet is the lowest: drop it
                  end else if (idx_ff == COUNT_W'(1)) begin
                     ins_in   = '0;
                     state_in = ST_WR_NEW;
                  end else begin
                     k_in     = '0;
                     rd_addr  = IDX_W'(1);
                     state_in = ST_SHIFT_DN;
                  end
               end else begin
                  grow_in = 1'b1;
                  if (at_end) begin
                     ins_in   = idx_ff[IDX_W-1:0];
                     state_in = ST_WR_NEW;
                  end else begin
                     k_in     = count_ff;
                     rd_addr  = IDX_W'(count_ff - COUNT_W'(1));
                     state_in = ST_SHIFT_UP;
                  end
               end
            end else if (rd.seq == seq_ff) begin
               ins_in   = idx_ff[IDX_W-1:0];  // replace in place
               grow_in  = 1'b0;
               state_in = ST_WR_NEW;
            end else begin
               idx_in  = idx_ff + COUNT_W'(1);
               rd_addr = IDX_W'(idx_ff + COUNT_W'(1));
            end
         end

         ST_SHIFT_UP: begin
            wr.we   = 1'b1;
            wr.addr = k_ff[IDX_W-1:0];
            wr.data = rd;
            if (k_ff - COUNT_W'(1) == idx_ff) begin
               ins_in   = idx_ff[IDX_W-1:0];
               state_in = ST_WR_NEW;
            end else begin
               k_in    = k_ff - COUNT_W'(1);
               rd_addr = IDX_W'(k_ff - COUNT_W'(2));
            end
         end

         ST_SHIFT_DN: begin
            wr.we   = 1'b1;
            wr.addr = k_ff[IDX_W-1:0];
            wr.data = rd;
            if (k_ff + COUNT_W'(2) == idx_ff) begin
               ins_in   = IDX_W'(idx_ff - COUNT_W'(1));
               state_in = ST_WR_NEW;
            end else begin
               k_in    = k_ff + COUNT_W'(1);
               rd_addr = IDX_W'(k_ff + COUNT_W'(2));
            end
         end

         ST_WR_NEW: begin
            wr.we         = 1'b1;
            wr.addr       = ins_ff;
            wr.data.seq   = seq_ff;
            wr.data.start = b_ff;
            wr.data.dur   = dur_ff;
            if (grow_ff) begin
               count_in = count_ff + COUNT_W'(1);
            end
            state_in = ST_IDLE;
         end

         ST_CHK_FIND: begin
            if (at_end || (idx_ff == '0 && rd.start > e_ff)) begin
               state_in = ST_FINISH;
            end else if (overlap) begin
               if (emit_ok) begin
                  emit_req       = 1'b1;
                  emit_res.kind  = RES_COVER;
                  emit_res.seq   = {16'd0, rd.seq[15:0]};
                  emit_res.start = rd.start;
                  emit_res.dur   = rd.dur;
                  prev_in        = rd.seq;
                  gap_done_in    = 1'b0;
                  idx_in         = idx_ff + COUNT_W'(1);
                  rd_addr        = IDX_W'(idx_ff + COUNT_W'(1));
                  state_in       = ST_CHK_WALK;
               end
            end else begin
               idx_in  = idx_ff + COUNT_W'(1);
               rd_addr = IDX_W'(idx_ff + COUNT_W'(1));
            end
         end

         ST_CHK_WALK: begin
            if (at_end || e_ff < stop) begin
               state_in = ST_FINISH;
            end else if (gap > 32'd1 && !gap_done_ff) begin
               // report the missing run first, then revisit this entry
               if (emit_ok) begin
                  emit_req      = 1'b1;
                  emit_res.kind = RES_MISS;
                  emit_res.seq  = prev_ff + 32'd1;
                  emit_res.miss = gap - 32'd1;
                  gap_done_in   = 1'b1;
               end
            end else if (!overlap || emit_ok) begin
               if (overlap) begin
                  emit_req       = 1'b1;
                  emit_res.kind  = RES_COVER;
                  emit_res.seq   = {16'd0, rd.seq[15:0]};
                  emit_res.start = rd.start;
                  emit_res.dur   = rd.dur;
               end
               prev_in     = rd.seq;
               gap_done_in = 1'b0;
               idx_in      = idx_ff + COUNT_W'(1);
               rd_addr     = IDX_W'(idx_ff + COUNT_W'(1));
            end
         end

         ST_DUMP: begin
            if (at_end) begin
               state_in = ST_FINISH;
            end else if (emit_ok) begin
               emit_req       = 1'b1;
               emit_res.kind  = RES_DUMP;
               emit_res.seq   = {16'd0, rd.seq[15:0]};
               emit_res.start = rd.start;
               emit_res.dur   = rd.dur;
               idx_in         = idx_ff + COUNT_W'(1);
               rd_addr        = IDX_W'(idx_ff + COUNT_W'(1));
            end
         end

         ST_FINISH: begin
            // flush the held result as the final one of this transaction
            if (!pend_v_ff) begin
               state_in = ST_IDLE;
            end else if (can_push) begin
               fin_req  = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // mark the held result as final when it leaves on a flush
   always_comb begin
      push_res      = pend_ff;
      push_res.last = fin_req;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         highest_ff <= '0;
         pend_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         highest_ff <= highest_in;
         if (emit_req) begin
            pend_v_ff <= 1'b1;
         end else if (fin_req) begin
            pend_v_ff <= 1'b0;
         end
         if ((emit_req || fin_req) && pend_v_ff) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      ins_ff      <= ins_in;
      grow_ff     <= grow_in;
      gap_done_ff <= gap_done_in;
      prev_ff     <= prev_in;
      seq_ff      <= seq_in;
      b_ff        <= b_in;
      e_ff        <= e_in;
      dur_ff      <= dur_in;
      if (emit_req) begin
         pend_ff <= emit_res;
      end
      if ((emit_req || fin_req) && pend_v_ff) begin
         out_ff <= push_res;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_ff.miss, out_ff.dur, out_ff.start, out_ff.seq};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;

endmodule
